FILE: hdl/binary_max_heap_queue_top_assert.svh
// Assertion macros for the heap queue checker.
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication
`define BMHQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// Next-cycle implication
`define BMHQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

FILE: hdl/bmhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

    // Data width of a queue entry
    localparam int unsigned DATA_W  = 32;
    // Width of the reported entry count
    localparam int unsigned ENTRY_W = 7;

    // Operation codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EMPTY_REMOVE = 2'd1,
        ST_FULL_DROP    = 2'd2
    } status_t;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic                     is_empty;
        logic [ENTRY_W-1:0]       entry_count;
        status_t                  status;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/bmhq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bmhq_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module bmhq_engine #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire bmhq_pkg::item_t  item,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output bmhq_pkg::result_t     res
);

    import bmhq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned PW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_LOAD,
        S_DN,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [PW-1:0]            cnt_reg, cnt_next;
    logic [PW-1:0]            pos_reg, pos_next;
    logic [PW-1:0]            child_pos_reg, child_pos_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] child_val_reg, child_val_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    status_t                  status_reg, status_next;

    // RAM side
    logic                     wr_en, rd_en;
    logic [PW-1:0]            wr_pos, rd_pos;
    logic signed [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0]        rd_raw;
    logic signed [DATA_W-1:0] rd_val;
    logic [PW-1:0]            wr_idx, rd_idx;

    // Shared comparator
    logic signed [DATA_W-1:0] cmp_a, cmp_b;
    logic                     cmp_lt;

    // Child positions of the current hole, and the entry count at their width
    logic [PW:0]              left_w, right_w, cnt_w;

    logic [ENTRY_W+PW-1:0]    cnt_ext;

    assign rd_val  = $signed(rd_raw);
    assign cmp_lt  = (cmp_a < cmp_b);
    assign left_w  = {pos_reg, 1'b0};
    assign right_w = {pos_reg, 1'b1};
    assign cnt_w   = {1'b0, cnt_reg};

    // Heap positions count from one
    assign wr_idx = wr_pos - PW'(1);
    assign rd_idx = rd_pos - PW'(1);

    bmhq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_raw)
    );

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        child_pos_next = child_pos_reg;
        val_next       = val_reg;
        child_val_next = child_val_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_pos         = pos_reg;
        wr_data        = val_reg;
        rd_en          = 1'b0;
        rd_pos         = pos_reg;
        cmp_a          = val_reg;
        cmp_b          = child_val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    status_next = ST_OK;
                    if (item.kind == KIND_INSERT)
                    begin
                        if (cnt_reg == PW'(CAPACITY))
                        begin
                            status_next = ST_FULL_DROP;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + PW'(1);
                            pos_next   = cnt_reg + PW'(1);
                            val_next   = item.value;
                            state_next = S_UP;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY_REMOVE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DN_LAST;
                        end
                    end
                end
            end

            // Sift up: hole at pos, moving value in val_reg
            S_UP:
            begin
                if (pos_reg == PW'(1))
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_pos     = pos_reg >> 1;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                cmp_a = rd_val;
                cmp_b = val_reg;
                wr_en = 1'b1;
                if (cmp_lt)
                begin
                    wr_data    = rd_val;
                    pos_next   = pos_reg >> 1;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Removal: fetch last entry, it becomes the moving value
            S_DN_LAST:
            begin
                rd_en      = 1'b1;
                rd_pos     = cnt_reg;
                cnt_next   = cnt_reg - PW'(1);
                pos_next   = PW'(1);
                state_next = S_DN_LOAD;
            end

            S_DN_LOAD:
            begin
                val_next   = rd_val;
                state_next = S_DN;
            end

            // Sift down: read left child if it exists
            S_DN:
            begin
                if (left_w > cnt_w)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_pos         = left_w[PW-1:0];
                    child_pos_next = left_w[PW-1:0];
                    state_next     = S_DN_LEFT;
                end
            end

            S_DN_LEFT:
            begin
                child_val_next = rd_val;
                if (right_w <= cnt_w)
                begin
                    rd_en      = 1'b1;
                    rd_pos     = right_w[PW-1:0];
                    state_next = S_DN_RIGHT;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            // Right child wins only when strictly larger
            S_DN_RIGHT:
            begin
                cmp_a = child_val_reg;
                cmp_b = rd_val;
                if (cmp_lt)
                begin
                    child_val_next = rd_val;
                    child_pos_next = right_w[PW-1:0];
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = child_val_reg;
                wr_en = 1'b1;
                if (cmp_lt)
                begin
                    wr_data    = child_val_reg;
                    pos_next   = child_pos_reg;
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Root mirror: every write to the root also lands here
    assign top_next = (wr_en && (wr_pos == PW'(1))) ? wr_data : top_reg;

    // State and registered values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            child_pos_reg <= '0;
            val_reg       <= '0;
            child_val_reg <= '0;
            top_reg       <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            child_pos_reg <= child_pos_next;
            val_reg       <= val_next;
            child_val_reg <= child_val_next;
            top_reg       <= top_next;
            status_reg    <= status_next;
        end
    end

    // Result view
    assign cnt_ext         = {{ENTRY_W{1'b0}}, cnt_reg};
    assign item_ready      = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.top_value   = (cnt_reg == '0) ? '0 : top_reg;
    assign res.is_empty    = (cnt_reg == '0);
    assign res.entry_count = cnt_ext[ENTRY_W-1:0];
    assign res.status      = status_reg;

endmodule

`default_nettype wire

FILE: hdl/binary_max_heap_queue_top.sv
// Insert and remove take longer the further the entry moves: L levels, where L <= log2(CAPACITY);
//   full/empty rejects skip the heap and go straight to the result.
// Throughput: one item at a time; set by the heap RAM, one read per cycle, per level step.
// A finished result sits in an output register, so the next item transfers meanwhile.
// Reset (rst_n low, async): queue empty, output register empty; RAM contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue_top #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire bmhq_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output bmhq_pkg::result_t      result
);

    import bmhq_pkg::*;

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    bmhq_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: refill when empty or being drained
    assign res_ready = !result_valid_reg || result_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (res_valid && res_ready)
        begin
            result_valid_next = 1'b1;
            result_next       = res;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: hdl/bmhq_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "binary_max_heap_queue_top_assert.svh"

module bmhq_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire bmhq_pkg::result_t result
);

    import bmhq_pkg::*;

    // A stalled result holds
    `BMHQ_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    // After a transfer in, the block is busy in the following cycle
    `BMHQ_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready)

    // Empty queue reports a zero maximum
    `BMHQ_ASSERT_NOW(a_empty_top_zero, result_valid && result.is_empty, result.top_value == '0)

    // A rejected removal only happens on an empty queue
    `BMHQ_ASSERT_NOW(a_reject_empty, result_valid && (result.status == ST_EMPTY_REMOVE),
                     result.is_empty)

endmodule

bind binary_max_heap_queue_top bmhq_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
